/* sv/rac_pkg.sv */
// Shared constants for the running autocorrelation block.
// Used by running_autocorrelation and its port checker; no dependencies.
package rac_pkg;

  localparam int MAX_LAG_DEF      = 15;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Result fields and packing of the master-side tdata.
  localparam int LAG_W       = 4;
  localparam int VALUE_W     = 64;
  localparam int OUT_TDATA_W = ((LAG_W + VALUE_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LAG       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NORMALIZE     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEEP_LAG0_RAW = 8'd2;

  localparam logic [LAG_W-1:0] MAX_LAG_RESET = 4'd15;

  // Q1.30 ratio and its saturation limits.
  localparam int Q_FRAC_BITS = 30;
  localparam int Q_W         = Q_FRAC_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(Q_FRAC_BITS + 1);

  localparam logic [VALUE_W-1:0] Q_POS_SAT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [VALUE_W-1:0] Q_NEG_SAT = 64'hFFFF_FFFF_8000_0000;
  localparam logic [VALUE_W-1:0] SUM_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] SUM_MIN   = 64'h8000_0000_0000_0000;

endpackage

/* sv/running_autocorrelation.sv */
// Each item runs through lags 0 to top (top = active highest lag) one lag at a time, paced by
// the one shared multiplier and the single read port of the lag-sum memory.
// A slice end then emits top+1 results; a normalized one comes from the one-bit-per-cycle
// restoring divider, which stops early when the ratio saturates.
// Reset (synchronous, active high) clears the valid bits of both memories at once, so the
// sums and the delay line read as zero; there is no clearing pass.
module running_autocorrelation #(
  parameter int MAX_LAG      = rac_pkg::MAX_LAG_DEF,
  parameter int SAMPLE_WIDTH = rac_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Slave side. tdata: sample; tlast: end_of_slice.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,
  input  logic                                 s_tlast,
  // Master side. tdata: lag [3:0], value [67:4], zero fill above; tlast: last.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rac_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                 m_tlast,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rac_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rac_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import rac_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int LW = $clog2(MAX_LAG + 1);
  localparam int HW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int CW = (LW > LAG_W) ? LW : LAG_W;
  localparam int PW = 2 * SW;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ACC  = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_LAT  = 8'b0000_1000,
    S_DIVS = 8'b0001_0000,
    S_DIVI = 8'b0010_0000,
    S_DIVF = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [LAG_W-1:0] cfg_max_lag;
  logic             cfg_normalize;
  logic             cfg_keep;

  // Per-item registers.
  logic signed [SW-1:0] x;
  logic                 eos;
  logic [LW-1:0]        top;
  logic [LW-1:0]        k;
  logic                 iss_on;

  // Memories and their valid bits.
  logic [VALUE_W-1:0] sums [MAX_LAG+1];
  logic [SW-1:0]      hist [MAX_LAG];
  logic [MAX_LAG:0]   sum_vld;
  logic [MAX_LAG-1:0] hist_vld;
  logic [HW-1:0]      wp;
  logic [HW-1:0]      haddr;
  logic [VALUE_W-1:0] sum_q;
  logic [SW-1:0]      hist_q;
  logic               sum_vq;
  logic               hist_vq;

  // Accumulation pipeline.
  logic                 p1_v;
  logic [LW-1:0]        p1_k;
  logic                 p2_v;
  logic [LW-1:0]        p2_k;
  logic                 p2_last;
  logic signed [SW-1:0] dsel;
  logic signed [PW-1:0] prod;
  logic [VALUE_W-1:0]   acc_a;
  logic [VALUE_W-1:0]   prod_ext;
  logic [VALUE_W-1:0]   add_s;
  logic [VALUE_W-1:0]   sum_new;

  // Output phase and divider.
  logic [VALUE_W-1:0]   sval;
  logic [VALUE_W-1:0]   den_now;
  logic                 nrm;
  logic [VALUE_W-1:0]   den;
  logic [VALUE_W-1:0]   num;
  logic [VALUE_W-1:0]   res;
  logic                 neg;
  logic [VALUE_W-1:0]   rem;
  logic [Q_W-1:0]       q;
  logic [DIV_CNT_W-1:0] cnt;
  logic [VALUE_W:0]     r2;
  logic                 r2_ge;
  logic                 out_free;
  logic [CW-1:0]        top_cmp;
  logic [LW:0]          hdiff;
  logic [LW:0]          hwrap;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // Active highest lag: the register limited to the built depth.
  assign top_cmp = (CW'(cfg_max_lag) > CW'(MAX_LAG)) ? CW'(MAX_LAG) : CW'(cfg_max_lag);

  // Delay-line slot of the sample k items back: (wp - k) modulo MAX_LAG.
  always_comb begin
    hdiff = (LW+1)'(wp) - (LW+1)'(k);
    hwrap = hdiff + (LW+1)'(MAX_LAG);
    haddr = hdiff[LW] ? HW'(hwrap) : HW'(hdiff);
  end

  // Stage 1 operand select and stage 2 saturating add.
  always_comb begin
    dsel     = (p1_k == '0) ? x : (hist_vq ? $signed(hist_q) : '0);
    prod_ext = {{(VALUE_W-PW){prod[PW-1]}}, prod};
    add_s    = acc_a + prod_ext;
    if ((acc_a[VALUE_W-1] == prod_ext[VALUE_W-1]) &&
        (add_s[VALUE_W-1] != acc_a[VALUE_W-1])) begin
      sum_new = acc_a[VALUE_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_new = add_s;
    end
  end

  // Output phase decode of the freshly read sum.
  always_comb begin
    sval    = sum_vq ? sum_q : '0;
    den_now = (k == '0) ? sval : den;
    nrm     = cfg_normalize && !den_now[VALUE_W-1] && (den_now != '0) &&
              !((k == '0) && cfg_keep);
    r2      = {rem, 1'b0};
    r2_ge   = (r2 >= {1'b0, den});
  end

  // Memories: one read and one write port each, registered read data.
  always_ff @(posedge clk) begin
    sum_q  <= sums[k];
    hist_q <= hist[haddr];
    if (p2_v) begin
      sums[p2_k] <= sum_new;
    end
    if (p2_v && p2_last) begin
      hist[wp] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld  <= '0;
      hist_vld <= '0;
      sum_vq   <= 1'b0;
      hist_vq  <= 1'b0;
    end else begin
      sum_vq  <= sum_vld[k];
      hist_vq <= hist_vld[haddr];
      if (p2_v) begin
        sum_vld[p2_k] <= 1'b1;
      end
      if (p2_v && p2_last) begin
        hist_vld[wp] <= 1'b1;
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_max_lag   <= MAX_LAG_RESET;
      cfg_normalize <= 1'b0;
      cfg_keep      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_LAG:       cfg_max_lag   <= cfg_data[LAG_W-1:0];
        REG_NORMALIZE:     cfg_normalize <= cfg_data[0];
        REG_KEEP_LAG0_RAW: cfg_keep      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Accumulation pipeline payload.
  always_ff @(posedge clk) begin
    prod    <= x * dsel;
    acc_a   <= sum_vq ? sum_q : '0;
    p1_k    <= k;
    p2_k    <= p1_k;
    p2_last <= (p1_k == top);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      k        <= '0;
      iss_on   <= 1'b0;
      p1_v     <= 1'b0;
      p2_v     <= 1'b0;
      wp       <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      p1_v <= (state == S_ACC) && iss_on;
      p2_v <= p1_v;
      // In S_EMIT a free output register is always reloaded below.
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            x      <= $signed(s_tdata[SW-1:0]);
            eos    <= s_tlast;
            top    <= LW'(top_cmp);
            k      <= '0;
            iss_on <= 1'b1;
            state  <= S_ACC;
          end
        end
        S_ACC: begin
          if (iss_on) begin
            if (k == top) begin
              iss_on <= 1'b0;
            end else begin
              k <= k + 1'b1;
            end
          end
          if (p2_v && p2_last) begin
            wp    <= (wp == HW'(MAX_LAG - 1)) ? '0 : wp + 1'b1;
            k     <= '0;
            state <= eos ? S_RD : S_IDLE;
          end
        end
        S_RD: begin
          state <= S_LAT;
        end
        S_LAT: begin
          if (k == '0) begin
            den <= sval;
          end
          num <= sval;
          res <= sval;
          state <= nrm ? S_DIVS : S_EMIT;
        end
        S_DIVS: begin
          neg   <= num[VALUE_W-1];
          rem   <= num[VALUE_W-1] ? (~num + 1'b1) : num;
          q     <= '0;
          cnt   <= '0;
          state <= S_DIVI;
        end
        S_DIVI: begin
          if (cnt == '0) begin
            // The integer part must be 0 or 1; two or more saturates.
            if ({1'b0, rem} >= {den, 1'b0}) begin
              res   <= neg ? Q_NEG_SAT : Q_POS_SAT;
              state <= S_EMIT;
            end else begin
              if (rem >= den) begin
                rem <= rem - den;
                q   <= Q_W'(1);
              end
              cnt <= cnt + 1'b1;
            end
          end else begin
            rem <= r2_ge ? VALUE_W'(r2 - {1'b0, den}) : r2[VALUE_W-1:0];
            q   <= {q[Q_W-2:0], r2_ge};
            if (cnt == DIV_CNT_W'(Q_FRAC_BITS)) begin
              state <= S_DIVF;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_DIVF: begin
          res   <= neg ? (~VALUE_W'(q) + 1'b1) : VALUE_W'(q);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(OUT_TDATA_W-LAG_W-VALUE_W)'(0), res, LAG_W'(k)};
            m_tlast  <= (k == top);
            if (k == top) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/rac_checker.sv */
// Port-level checks for running_autocorrelation, attached by the bind below.
// Depends on rac_pkg for the result bus width.
module rac_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rac_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tlast
);
  import rac_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // No sample is taken while a slice still has results to come.
  a_no_input_mid_slice: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of a slice");

  // The bits above the value field of a result are always zero.
  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:LAG_W+VALUE_W] == '0)
    else $error("result fill bits not zero");

  // An accepted sample is worked on before the next one is taken.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a sample transaction");

endmodule

bind running_autocorrelation rac_checker u_rac_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
